@@ src/tma_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_pkg
// Shared constants, codes and types of the triangle mesh edge adjacency core.
// ----------------------------------------------------------------------------
package tma_pkg;

  localparam int MAX_TRIANGLES = 1024;
  localparam int HASH_SLOTS    = 4096;
  localparam int NODE_BITS     = 16;

  localparam int TRI_BITS   = $clog2(MAX_TRIANGLES);
  localparam int COUNT_BITS = TRI_BITS + 1;
  localparam int SLOT_BITS  = $clog2(HASH_SLOTS);
  localparam int SIDE_BITS  = 2;
  localparam int FULL_BITS  = COUNT_BITS + 2;
  localparam int NB_BITS    = 11;
  localparam int NE_BITS    = 3;

  localparam logic [63:0] MIX_C1    = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;
  localparam int          MIX_SHIFT = 33;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_LOAD   = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  localparam logic signed [NB_BITS-1:0] NB_NONE = -11'sd1;
  localparam logic signed [NE_BITS-1:0] NE_NONE = -3'sd1;

  typedef struct packed {
    logic                 used;
    logic [NODE_BITS-1:0] from;
    logic [NODE_BITS-1:0] to;
    logic [TRI_BITS-1:0]  owner;
    logic [SIDE_BITS-1:0] side;
  } edge_entry_t;

endpackage

@@ src/triangle_mesh_edge_adjacency_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_mesh_edge_adjacency_core
// Edge hash based triangle neighbour table with load, query and clear items.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  in      | in_valid_i / in_stall_o    | mode, node_a/b/c, query_index
//  out     | out_valid_o / out_stall_i  | status, assigned_index, neighbours,
//          |                            | neighbour edges, boundary_count
//
//  One item at a time. Each hash runs on one shared 32x32 multiplier, two
//  hashes per edge, and each table probe uses the edge table read port
//  (S_RD, then S_CMP); a query first reads its triangle in S_TRI, and a
//  rejected load or query and an unused mode go straight to S_DONE.
//  After reset and after a clear item a sweep over all HASH_SLOTS slots
//  empties the edge table. A result waits in the output register while
//  out_stall_i holds it; the next item is then already taken.
// ----------------------------------------------------------------------------
module triangle_mesh_edge_adjacency_core
  import tma_pkg::*;
(
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        mode_i,
  input  logic [NODE_BITS-1:0]              node_a_i,
  input  logic [NODE_BITS-1:0]              node_b_i,
  input  logic [NODE_BITS-1:0]              node_c_i,
  input  logic [TRI_BITS-1:0]               query_index_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        status_o,
  output logic [TRI_BITS-1:0]               assigned_index_o,
  output logic signed [NB_BITS-1:0]         neighbour_0_o,
  output logic signed [NB_BITS-1:0]         neighbour_1_o,
  output logic signed [NB_BITS-1:0]         neighbour_2_o,
  output logic signed [NE_BITS-1:0]         neighbour_edge_0_o,
  output logic signed [NE_BITS-1:0]         neighbour_edge_1_o,
  output logic signed [NE_BITS-1:0]         neighbour_edge_2_o,
  output logic [1:0]                        boundary_count_o
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_TRI   = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_ACC   = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  edge_entry_t          edge_mem [HASH_SLOTS];
  logic [3*NODE_BITS-1:0] tri_mem [MAX_TRIANGLES];

  logic [3:0]            state_q;
  logic [SLOT_BITS-1:0]  clr_q;
  logic                  clr_item_q;
  logic [COUNT_BITS-1:0] count_q;
  logic                  err_q;
  logic                  is_load_q;
  logic [1:0]            k_q;
  logic [2:0]            op_q;
  logic                  hsel_q;
  logic [NODE_BITS-1:0]  na_q, nb_q, nc_q;
  logic [63:0]           prod_q, acc_q, v_q;
  logic [SLOT_BITS-1:0]  hash_q, slot_q, probe_q;
  edge_entry_t           ent_q;
  logic [3*NODE_BITS-1:0] tri_q;

  logic [1:0]                      res_status_q;
  logic [TRI_BITS-1:0]             res_assigned_q;
  logic signed [NB_BITS-1:0]       res_nb_q [3];
  logic signed [NE_BITS-1:0]       res_ne_q [3];
  logic [1:0]                      res_bc_q;

  logic                            out_valid_q;
  logic [1:0]                      out_status_q;
  logic [TRI_BITS-1:0]             out_assigned_q;
  logic signed [NB_BITS-1:0]       out_nb_q [3];
  logic signed [NE_BITS-1:0]       out_ne_q [3];
  logic [1:0]                      out_bc_q;

  logic                  in_xfer;
  logic                  out_free;
  logic [NODE_BITS-1:0]  lf, lt, edge_from, edge_to;
  logic [31:0]           mul_a, mul_b;
  logic [63:0]           prod_d, acc_d, fold_d;
  logic                  acc_clear;
  logic [SLOT_BITS-1:0]  mix_d;
  logic                  full;
  logic [FULL_BITS-1:0]  need3;
  logic                  hit, probe_last;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    case (k_q)
      2'd0:    begin lf = nb_q; lt = nc_q; end
      2'd1:    begin lf = nc_q; lt = na_q; end
      default: begin lf = na_q; lt = nb_q; end
    endcase
    edge_from = is_load_q ? lf : lt;
    edge_to   = is_load_q ? lt : lf;
  end

  always_comb begin
    case (op_q)
      3'd0:    begin mul_a = 32'(hsel_q ? edge_to : edge_from); mul_b = MIX_C1[31:0];  end
      3'd1:    begin mul_a = 32'(hsel_q ? edge_to : edge_from); mul_b = MIX_C1[63:32]; end
      3'd2:    begin mul_a = v_q[31:0];  mul_b = MIX_C2[31:0];  end
      3'd3:    begin mul_a = v_q[31:0];  mul_b = MIX_C2[63:32]; end
      3'd4:    begin mul_a = v_q[63:32]; mul_b = MIX_C2[31:0];  end
      default: begin mul_a = '0;         mul_b = '0;            end
    endcase
  end

  assign prod_d    = mul_a * mul_b;
  assign acc_clear = (op_q == 3'd0) || (op_q == 3'd2);
  assign acc_d     = acc_clear ? prod_q : acc_q + {prod_q[31:0], 32'd0};
  assign fold_d    = acc_d ^ (acc_d >> MIX_SHIFT);
  assign mix_d     = fold_d[SLOT_BITS-1:0];

  assign need3 = FULL_BITS'(3) * (FULL_BITS'(count_q) + FULL_BITS'(1));
  assign full  = (count_q >= COUNT_BITS'(MAX_TRIANGLES)) ||
                 (need3 > FULL_BITS'(HASH_SLOTS));

  assign hit        = ent_q.used && (ent_q.from == edge_from) && (ent_q.to == edge_to);
  assign probe_last = (probe_q == '1);

  always_ff @(posedge clk_i) begin
    ent_q <= edge_mem[slot_q];
    tri_q <= tri_mem[query_index_i];
    if (state_q == S_CLEAR) begin
      edge_mem[clr_q] <= '0;
    end else if (state_q == S_CMP && is_load_q && !ent_q.used) begin
      edge_mem[slot_q] <= '{used: 1'b1, from: edge_from, to: edge_to,
                            owner: count_q[TRI_BITS-1:0], side: k_q};
    end
    if (state_q == S_CMP && is_load_q && k_q == 2'd2 && !hit &&
        (!ent_q.used || probe_last)) begin
      tri_mem[count_q[TRI_BITS-1:0]] <= {na_q, nb_q, nc_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      clr_item_q  <= 1'b0;
      count_q     <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + SLOT_BITS'(1);
          if (clr_q == '1) begin
            state_q <= clr_item_q ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            unique case (mode_i)
              MODE_CLEAR: begin
                count_q    <= '0;
                err_q      <= 1'b0;
                clr_q      <= '0;
                clr_item_q <= 1'b1;
                state_q    <= S_CLEAR;
              end
              MODE_LOAD: begin
                state_q <= (err_q || full) ? S_DONE : S_MUL;
              end
              MODE_QUERY: begin
                state_q <= (err_q || COUNT_BITS'(query_index_i) >= count_q) ? S_DONE
                                                                            : S_TRI;
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_TRI: state_q <= S_MUL;
        S_MUL: state_q <= S_ACC;
        S_ACC: begin
          if (op_q == 3'd4 && hsel_q) begin
            state_q <= S_RD;
          end else begin
            state_q <= S_MUL;
          end
        end
        S_RD: state_q <= S_CMP;
        S_CMP: begin
          if (hit) begin
            if (is_load_q) begin
              err_q   <= 1'b1;
              state_q <= S_DONE;
            end else begin
              state_q <= (k_q == 2'd2) ? S_DONE : S_MUL;
            end
          end else if (!ent_q.used || probe_last) begin
            if (k_q == 2'd2) begin
              if (is_load_q) begin
                count_q <= count_q + COUNT_BITS'(1);
              end
              state_q <= S_DONE;
            end else begin
              state_q <= S_MUL;
            end
          end else begin
            state_q <= S_RD;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            clr_item_q  <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        k_q    <= 2'd0;
        op_q   <= 3'd0;
        hsel_q <= 1'b0;
        na_q   <= node_a_i;
        nb_q   <= node_b_i;
        nc_q   <= node_c_i;
        is_load_q      <= (mode_i == MODE_LOAD);
        res_status_q   <= ST_OK;
        res_assigned_q <= '0;
        res_bc_q       <= 2'd0;
        for (int i = 0; i < 3; i++) begin
          res_nb_q[i] <= NB_NONE;
          res_ne_q[i] <= NE_NONE;
        end
        unique case (mode_i)
          MODE_CLEAR: ;
          MODE_LOAD: begin
            res_assigned_q <= count_q[TRI_BITS-1:0];
            if (err_q) begin
              res_status_q <= ST_BAD;
            end else if (full) begin
              res_status_q <= ST_FULL;
            end
          end
          MODE_QUERY: begin
            if (err_q || COUNT_BITS'(query_index_i) >= count_q) begin
              res_status_q <= ST_BAD;
            end else begin
              res_bc_q <= 2'd3;
            end
          end
          default: res_status_q <= ST_BAD;
        endcase
      end
      S_TRI: begin
        na_q <= tri_q[3*NODE_BITS-1:2*NODE_BITS];
        nb_q <= tri_q[2*NODE_BITS-1:NODE_BITS];
        nc_q <= tri_q[NODE_BITS-1:0];
      end
      S_MUL: prod_q <= prod_d;
      S_ACC: begin
        acc_q <= acc_d;
        if (op_q == 3'd1) begin
          v_q <= fold_d;
        end
        if (op_q == 3'd4) begin
          op_q   <= 3'd0;
          hsel_q <= !hsel_q;
          if (hsel_q) begin
            slot_q  <= hash_q ^ mix_d;
            probe_q <= '0;
          end else begin
            hash_q <= mix_d;
          end
        end else begin
          op_q <= op_q + 3'd1;
        end
      end
      S_CMP: begin
        if (hit || !ent_q.used || probe_last) begin
          k_q <= k_q + 2'd1;
          if (hit && is_load_q) begin
            res_status_q <= ST_DUP;
          end
          if (hit && !is_load_q) begin
            res_nb_q[k_q] <= NB_BITS'(ent_q.owner);
            res_ne_q[k_q] <= NE_BITS'(ent_q.side);
            res_bc_q      <= res_bc_q - 2'd1;
          end
        end else begin
          slot_q  <= slot_q + SLOT_BITS'(1);
          probe_q <= probe_q + SLOT_BITS'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_status_q   <= res_status_q;
          out_assigned_q <= res_assigned_q;
          out_bc_q       <= res_bc_q;
          out_nb_q       <= res_nb_q;
          out_ne_q       <= res_ne_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = out_status_q;
  assign assigned_index_o   = out_assigned_q;
  assign neighbour_0_o      = out_nb_q[0];
  assign neighbour_1_o      = out_nb_q[1];
  assign neighbour_2_o      = out_nb_q[2];
  assign neighbour_edge_0_o = out_ne_q[0];
  assign neighbour_edge_1_o = out_ne_q[1];
  assign neighbour_edge_2_o = out_ne_q[2];
  assign boundary_count_o   = out_bc_q;

endmodule

@@ src/tma_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_checker
// Port level checks of the triangle mesh edge adjacency core.
// ----------------------------------------------------------------------------
module tma_checker
  import tma_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [1:0]                status_o,
  input logic signed [NB_BITS-1:0] neighbour_0_o,
  input logic signed [NE_BITS-1:0] neighbour_edge_0_o,
  input logic [1:0]                boundary_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output dropped while stalled");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is at work");

  a_bad_no_nb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> neighbour_0_o == NB_NONE &&
    boundary_count_o == 2'd0)
    else $error("failed item reports a neighbour");

  a_edge_pairs_nb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && neighbour_edge_0_o == NE_NONE |-> neighbour_0_o == NB_NONE)
    else $error("neighbour without edge number");

endmodule

bind triangle_mesh_edge_adjacency_core tma_checker u_tma_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .status_o           (status_o),
  .neighbour_0_o      (neighbour_0_o),
  .neighbour_edge_0_o (neighbour_edge_0_o),
  .boundary_count_o   (boundary_count_o)
);

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the triangle mesh edge adjacency core.
// Drives clear, load, query and unused-mode items with random gaps and stalls.
// An in-bench adjacency model predicts every result, and a monitor compares
// each result field by field. Covered: error and full cases, a store filled
// to capacity, meshes with shared edges, and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import tma_pkg::*;

  localparam int RUN_LIMIT    = 3000000;
  localparam int RANDOM_ITEMS = 850;

  typedef struct packed {
    logic [1:0]                status;
    logic [TRI_BITS-1:0]       assigned;
    logic signed [NB_BITS-1:0] nb0, nb1, nb2;
    logic signed [NE_BITS-1:0] ne0, ne1, ne2;
    logic [1:0]                bcount;
  } adjacency_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] mode = MODE_CLEAR;
  logic [NODE_BITS-1:0] node_a = '0, node_b = '0, node_c = '0;
  logic [TRI_BITS-1:0] query_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  adjacency_t got;

  triangle_mesh_edge_adjacency_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .mode_i(mode), .node_a_i(node_a), .node_b_i(node_b), .node_c_i(node_c),
    .query_index_i(query_index),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(got.status), .assigned_index_o(got.assigned),
    .neighbour_0_o(got.nb0), .neighbour_1_o(got.nb1), .neighbour_2_o(got.nb2),
    .neighbour_edge_0_o(got.ne0), .neighbour_edge_1_o(got.ne1),
    .neighbour_edge_2_o(got.ne2), .boundary_count_o(got.bcount)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // adjacency model state
  logic [NODE_BITS-1:0] mesh_nodes [MAX_TRIANGLES][3];
  logic                 slot_used  [HASH_SLOTS];
  logic [NODE_BITS-1:0] slot_from  [HASH_SLOTS];
  logic [NODE_BITS-1:0] slot_to    [HASH_SLOTS];
  logic [TRI_BITS-1:0]  slot_owner [HASH_SLOTS];
  logic [SIDE_BITS-1:0] slot_side  [HASH_SLOTS];
  int unsigned          mesh_count;
  logic                 mesh_error;

  adjacency_t pending_results[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int cycles = 0;
  bit calm = 1'b0;
  int hold_cycles = 0;

  function automatic logic [63:0] fmix64(logic [63:0] v);
    v = v ^ (v >> MIX_SHIFT);
    v = v * MIX_C1;
    v = v ^ (v >> MIX_SHIFT);
    v = v * MIX_C2;
    v = v ^ (v >> MIX_SHIFT);
    return v;
  endfunction

  function automatic int home_of(logic [NODE_BITS-1:0] f, logic [NODE_BITS-1:0] t);
    logic [63:0] h;
    h = fmix64(64'(f)) ^ fmix64(64'(t));
    return int'(h % HASH_SLOTS);
  endfunction

  function automatic int find_edge_slot(logic [NODE_BITS-1:0] f, logic [NODE_BITS-1:0] t);
    int s;
    s = home_of(f, t);
    for (int n = 0; n < HASH_SLOTS; n++) begin
      if (!slot_used[s]) return -1;
      if (slot_from[s] == f && slot_to[s] == t) return s;
      s = (s + 1) % HASH_SLOTS;
    end
    return -1;
  endfunction

  function automatic bit add_edge(logic [NODE_BITS-1:0] f, logic [NODE_BITS-1:0] t,
                                  int owner, int side);
    int s;
    s = home_of(f, t);
    for (int n = 0; n < HASH_SLOTS; n++) begin
      if (!slot_used[s]) begin
        slot_used[s] = 1'b1;
        slot_from[s] = f;
        slot_to[s] = t;
        slot_owner[s] = TRI_BITS'(owner);
        slot_side[s] = SIDE_BITS'(side);
        return 1'b1;
      end
      if (slot_from[s] == f && slot_to[s] == t) return 1'b0;
      s = (s + 1) % HASH_SLOTS;
    end
    return 1'b1;
  endfunction

  function automatic void clear_mesh();
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    mesh_count = 0;
    mesh_error = 1'b0;
  endfunction

  function automatic adjacency_t predict_adjacency(logic [1:0] m, logic [NODE_BITS-1:0] a,
      logic [NODE_BITS-1:0] b, logic [NODE_BITS-1:0] c, logic [TRI_BITS-1:0] q);
    adjacency_t r;
    logic [NODE_BITS-1:0] ef[3], et[3];
    logic signed [NB_BITS-1:0] nb[3];
    logic signed [NE_BITS-1:0] ne[3];
    bit ok;
    int s;
    r = '0;
    nb = '{NB_NONE, NB_NONE, NB_NONE};
    ne = '{NE_NONE, NE_NONE, NE_NONE};
    if (m == MODE_CLEAR) begin
      clear_mesh();
    end else if (m == MODE_LOAD) begin
      r.assigned = mesh_count[TRI_BITS-1:0];
      if (mesh_error) begin
        r.status = ST_BAD;
      end else if (mesh_count >= MAX_TRIANGLES || 3 * (mesh_count + 1) > HASH_SLOTS) begin
        r.status = ST_FULL;
      end else begin
        ef = '{b, c, a};
        et = '{c, a, b};
        ok = 1'b1;
        for (int k = 0; k < 3 && ok; k++) ok = add_edge(ef[k], et[k], mesh_count, k);
        if (ok) begin
          mesh_nodes[mesh_count] = '{a, b, c};
          mesh_count++;
        end else begin
          mesh_error = 1'b1;
          r.status = ST_DUP;
        end
      end
    end else if (m == MODE_QUERY) begin
      if (mesh_error || q >= mesh_count) begin
        r.status = ST_BAD;
      end else begin
        ef = '{mesh_nodes[q][2], mesh_nodes[q][0], mesh_nodes[q][1]};
        et = '{mesh_nodes[q][1], mesh_nodes[q][2], mesh_nodes[q][0]};
        r.bcount = 2'd3;
        for (int k = 0; k < 3; k++) begin
          s = find_edge_slot(ef[k], et[k]);
          if (s >= 0) begin
            nb[k] = NB_BITS'(slot_owner[s]);
            ne[k] = NE_BITS'(slot_side[s]);
            r.bcount--;
          end
        end
      end
    end else begin
      r.status = ST_BAD;
    end
    {r.nb0, r.nb1, r.nb2} = {nb[0], nb[1], nb[2]};
    {r.ne0, r.ne1, r.ne2} = {ne[0], ne[1], ne[2]};
    return r;
  endfunction

  task automatic report(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  task automatic check_field(string name, int actual, int wanted);
    if (actual != wanted)
      report($sformatf("result %0d %s got %0d expected %0d", results_seen, name, actual,
                       wanted));
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    adjacency_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report("result with no transfer outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("status", int'(got.status), int'(want.status));
        check_field("assigned_index", int'(got.assigned), int'(want.assigned));
        check_field("neighbour_0", int'(got.nb0), int'(want.nb0));
        check_field("neighbour_1", int'(got.nb1), int'(want.nb1));
        check_field("neighbour_2", int'(got.nb2), int'(want.nb2));
        check_field("neighbour_edge_0", int'(got.ne0), int'(want.ne0));
        check_field("neighbour_edge_1", int'(got.ne1), int'(want.ne1));
        check_field("neighbour_edge_2", int'(got.ne2), int'(want.ne2));
        check_field("boundary_count", int'(got.bcount), int'(want.bcount));
      end
      results_seen++;
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 33);
    end
  end

  task automatic send_item(logic [1:0] m, logic [NODE_BITS-1:0] a, logic [NODE_BITS-1:0] b,
                           logic [NODE_BITS-1:0] c, logic [TRI_BITS-1:0] q);
    if (!calm && $urandom_range(0, 99) < 33) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    mode <= m;
    node_a <= a;
    node_b <= b;
    node_c <= c;
    query_index <= q;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_adjacency(m, a, b, c, q));
    items_sent++;
  endtask

  task automatic send_clear();
    send_item(MODE_CLEAR, NODE_BITS'($urandom), NODE_BITS'($urandom), NODE_BITS'($urandom),
              TRI_BITS'($urandom));
  endtask

  task automatic send_load(logic [NODE_BITS-1:0] a, logic [NODE_BITS-1:0] b,
                           logic [NODE_BITS-1:0] c);
    send_item(MODE_LOAD, a, b, c, TRI_BITS'($urandom));
  endtask

  task automatic send_query(int q);
    send_item(MODE_QUERY, NODE_BITS'($urandom), NODE_BITS'($urandom), NODE_BITS'($urandom),
              TRI_BITS'(q));
  endtask

  task automatic send_unused(logic [NODE_BITS-1:0] a, logic [NODE_BITS-1:0] b,
                             logic [NODE_BITS-1:0] c, logic [TRI_BITS-1:0] q);
    send_item(MODE_UNUSED, a, b, c, q);
  endtask

  // load a consistently oriented grid mesh: two triangles per cell
  task automatic load_grid(int cols, int rows, logic [NODE_BITS-1:0] base);
    logic [NODE_BITS-1:0] p00, p10, p01, p11;
    for (int y = 0; y < rows; y++)
      for (int x = 0; x < cols; x++) begin
        p00 = NODE_BITS'(base + y * (cols + 1) + x);
        p10 = NODE_BITS'(p00 + 1);
        p01 = NODE_BITS'(p00 + cols + 1);
        p11 = NODE_BITS'(p01 + 1);
        send_load(p00, p10, p11);
        send_load(p00, p11, p01);
      end
  endtask

  task automatic test_directed();
    send_query(0);
    send_unused(16'hffff, 16'hffff, 16'hffff, 10'h3ff);
    send_load(16'h0000, 16'hffff, 16'haaaa);
    send_load(16'hffff, 16'h0000, 16'h5555);
    send_load(1, 2, 3);
    send_load(3, 2, 4);
    send_query(0);
    send_query(1);
    send_query(2);
    send_query(3);
    send_query(4);
    send_query(10'h3ff);
    send_load(5, 5, 5);
    send_load(7, 8, 9);
    send_query(0);
    send_clear();
    send_load(1, 2, 3);
    send_load(1, 2, 3);
    send_query(0);
    send_clear();
    send_query(0);
  endtask

  task automatic test_backpressure();
    calm = 1'b1;
    send_clear();
    load_grid(2, 1, 16'h1234);
    hold_cycles = 600;
    for (int i = 0; i < 16; i++) send_query($urandom_range(0, 4));
    calm = 1'b0;
  endtask

  task automatic test_fill();
    send_clear();
    load_grid(32, 16, NODE_BITS'($urandom));
    send_load(16'hfff0, 16'hfff1, 16'hfff2);
    send_query(10'h3ff);
    send_query(0);
  endtask

  task automatic test_random();
    int base_items, tris, pick;
    base_items = items_sent;
    while (items_sent - base_items < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 5) == 0);
      send_clear();
      load_grid($urandom_range(1, 6), $urandom_range(1, 6), NODE_BITS'($urandom));
      tris = mesh_count;
      for (int i = 0; i < tris + 10; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          send_query($urandom_range(0, tris - 1));
        end else if (pick < 85) begin
          send_query($urandom);
        end else if (pick < 93) begin
          send_load(NODE_BITS'($urandom), NODE_BITS'($urandom), NODE_BITS'($urandom));
        end else if (pick < 97) begin
          send_unused(NODE_BITS'($urandom), NODE_BITS'($urandom), NODE_BITS'($urandom),
                      TRI_BITS'($urandom));
        end else begin
          pick = $urandom_range(0, tris - 1);
          send_load(mesh_nodes[pick][0], mesh_nodes[pick][1], mesh_nodes[pick][2]);
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    int waited;
    clear_mesh();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_fill();
    test_random();
    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (300) @(posedge clk);
    $display("%0d transfers sent, %0d results checked in %0d cycles", items_sent,
             results_seen, cycles);
    $display("covered: clear, load, query, unused mode, duplicate, full store, hold-off");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_results.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
